// ===== hw/rtl/combinadic_rank_codec16_macros.svh =====
// assertion macros for the combinadic rank codec checker
// no dependencies; included by the checker file only
`ifndef COMBINADIC_RANK_CODEC16_MACROS_SVH
`define COMBINADIC_RANK_CODEC16_MACROS_SVH

// same-cycle implication, disabled during reset
`define CMB_ASSERT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define CMB_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== hw/rtl/cmbrc16_pkg.sv =====
// shared types, constants and binomial helpers for the combinadic rank codec
// no dependencies; imported by the top level and the checker
package cmbrc16_pkg;

  // default pattern width and pipeline slicing
  localparam int unsigned PATTERN_BITS_DEF = 16;
  localparam int unsigned STEPS_PER_STAGE  = 2;

  // payload field widths
  localparam int unsigned PATTERN_W = 16;
  localparam int unsigned RANK_W    = 14;
  localparam int unsigned COUNT_W   = 5;
  localparam int unsigned CW_W      = 4;
  localparam int unsigned IDX_DEPTH = 32;

  // command codes
  typedef enum logic {
    CMD_ENCODE = 1'b0,
    CMD_DECODE = 1'b1
  } cmd_e;

  // input item
  typedef struct packed {
    cmd_e                 command;
    logic [PATTERN_W-1:0] pattern_in;
    logic [RANK_W-1:0]    rank_in;
    logic [COUNT_W-1:0]   popcount_in;
  } in_t;

  // result item
  typedef struct packed {
    logic [PATTERN_W-1:0] pattern_out;
    logic [RANK_W-1:0]    rank_out;
    logic [COUNT_W-1:0]   popcount_out;
    logic [CW_W-1:0]      code_width;
    logic                 rank_error;
  } out_t;

  // binomial coefficient by pascal rows, zero when r > n
  function automatic int unsigned binom_f(input int unsigned n, input int unsigned r);
    int unsigned row [0:IDX_DEPTH];
    for (int j = 0; j <= IDX_DEPTH; j++) begin
      row[j] = 0;
    end
    row[0] = 1;
    for (int unsigned m = 1; m <= n; m++) begin
      for (int unsigned j = m; j >= 1; j--) begin
        if (j <= IDX_DEPTH) begin
          row[j] = row[j] + row[j-1];
        end
      end
    end
    return (r <= IDX_DEPTH) ? row[r] : 0;
  endfunction

  // packing width ceil(log2 C(n,k)), zero when at most one pattern exists
  function automatic int unsigned width_f(input int unsigned n, input int unsigned k);
    int unsigned count;
    int unsigned bits;
    count = binom_f(n, k);
    bits  = 0;
    if (count > 1) begin
      for (int unsigned b = 0; b < 31; b++) begin
        if ((32'd1 << b) < count) begin
          bits = b + 1;
        end
      end
    end
    return bits;
  endfunction

endpackage

// ===== hw/rtl/combinadic_rank_codec16.sv =====
// Combinadic rank codec for 16-bit occupancy patterns, encode and decode.
// Channels: in_valid_i/in_ready_o with in_data_i (cmbrc16_pkg::in_t) and
// out_valid_o/out_ready_i with out_data_o (cmbrc16_pkg::out_t); an item moves
// when valid and ready are both high at a rising clk_i edge.
// command encode: popcount, colex rank and packing width of pattern_in.
// command decode: rebuilds the pattern of rank_in with popcount_in set bits;
// a rank at or above C(PATTERN_BITS, popcount_in) raises rank_error with
// pattern_out zero, rank and popcount echoed.
// Throughput: one item per cycle while out_ready_i stays high. A front stage
// counts bits and checks the range, then each of the following stages walks
// two bit positions from the top down, doing one table compare and add or
// subtract per position.
// Reset (rst_ni low, asynchronous) empties the pipeline; no item is lost or
// invented. When the receiver stalls, the last stage holds its item and
// stages behind it keep filling bubbles; in_ready_o drops only once every
// stage holds an item.
module combinadic_rank_codec16 #(
  parameter int unsigned PATTERN_BITS = cmbrc16_pkg::PATTERN_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  cmbrc16_pkg::in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output cmbrc16_pkg::out_t  out_data_o
);
  import cmbrc16_pkg::*;

  localparam int unsigned BinomW  = $clog2(binom_f(PATTERN_BITS, PATTERN_BITS / 2) + 1);
  localparam int unsigned AccW    = (BinomW > RANK_W) ? BinomW : RANK_W;
  localparam int unsigned NumStg  = (PATTERN_BITS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  localparam int unsigned NumGrp  = (PATTERN_BITS + 3) / 4;

  // per-stage payload
  typedef struct packed {
    cmd_e                    cmd;
    logic                    err;
    logic [COUNT_W-1:0]      k;
    logic [COUNT_W-1:0]      idx;
    logic [CW_W-1:0]         cw;
    logic [RANK_W-1:0]       rank;
    logic [AccW-1:0]         acc;
    logic [PATTERN_BITS-1:0] pat;
  } stg_t;

  // constant tables
  logic [BinomW-1:0] binom_tbl [PATTERN_BITS][IDX_DEPTH];
  logic [BinomW-1:0] full_tbl  [IDX_DEPTH];
  logic [CW_W-1:0]   cw_tbl    [IDX_DEPTH];

  for (genvar r = 0; r < IDX_DEPTH; r++) begin : g_tbl_r
    assign full_tbl[r] = BinomW'(binom_f(PATTERN_BITS, r));
    assign cw_tbl[r]   = CW_W'(width_f(PATTERN_BITS, r));
    for (genvar p = 0; p < PATTERN_BITS; p++) begin : g_tbl_p
      assign binom_tbl[p][r] = BinomW'(binom_f(p, r));
    end
  end

  // one position of the top-down walk
  function automatic stg_t step_f(input stg_t cur, input logic [BinomW-1:0] term,
                                  input logic [PATTERN_BITS-1:0] sel);
    stg_t            nxt;
    logic [AccW-1:0] t;
    nxt = cur;
    t   = AccW'(term);
    if (cur.cmd == CMD_ENCODE) begin
      if ((cur.pat & sel) != '0) begin
        nxt.acc = cur.acc + t;
        nxt.idx = cur.idx - COUNT_W'(1);
      end
    end else if (!cur.err && (cur.idx != '0) && (cur.acc >= t)) begin
      nxt.pat = cur.pat | sel;
      nxt.acc = cur.acc - t;
      nxt.idx = cur.idx - COUNT_W'(1);
    end
    return nxt;
  endfunction

  stg_t [NumStg:0] st_d;
  stg_t [NumStg:0] st_q;
  logic [NumStg:0] vld_d;
  logic [NumStg:0] vld_q;
  logic [NumStg:0] en;

  // front stage: mask, popcount, range check
  logic [PATTERN_BITS+PATTERN_W-1:0] pin_ext;
  logic [PATTERN_BITS-1:0]           pat_m;
  logic [PATTERN_BITS+3:0]           pad_ext;
  logic [2:0]                        grp_cnt [NumGrp];
  logic [COUNT_W-1:0]                popcnt;
  stg_t                              prep;

  assign pin_ext = {{PATTERN_BITS{1'b0}}, in_data_i.pattern_in};
  assign pat_m   = pin_ext[PATTERN_BITS-1:0];
  assign pad_ext = {4'b0, pat_m};

  for (genvar g = 0; g < NumGrp; g++) begin : g_grp
    assign grp_cnt[g] = 3'(pad_ext[4*g]) + 3'(pad_ext[4*g+1]) +
                        3'(pad_ext[4*g+2]) + 3'(pad_ext[4*g+3]);
  end

  always_comb begin
    popcnt = '0;
    for (int g = 0; g < NumGrp; g++) begin
      popcnt = popcnt + COUNT_W'(grp_cnt[g]);
    end
  end

  always_comb begin
    prep      = '0;
    prep.cmd  = in_data_i.command;
    prep.rank = in_data_i.rank_in;
    if (in_data_i.command == CMD_DECODE) begin
      prep.k   = in_data_i.popcount_in;
      prep.err = AccW'(in_data_i.rank_in) >= AccW'(full_tbl[in_data_i.popcount_in]);
      prep.acc = AccW'(in_data_i.rank_in);
    end else begin
      prep.k   = popcnt;
      prep.pat = pat_m;
    end
    prep.idx = prep.k;
    prep.cw  = cw_tbl[prep.k];
  end

  assign st_d[0]  = prep;
  assign vld_d[0] = in_valid_i;

  // walk stages, two positions each from the top bit down
  for (genvar s = 1; s <= NumStg; s++) begin : g_stg
    stg_t [STEPS_PER_STAGE:0] chain;
    assign chain[0] = st_q[s-1];
    for (genvar j = 0; j < STEPS_PER_STAGE; j++) begin : g_step
      localparam int Pos = PATTERN_BITS - 1 - ((s - 1) * STEPS_PER_STAGE + j);
      if (Pos >= 0) begin : g_act
        assign chain[j+1] = step_f(chain[j], binom_tbl[Pos][chain[j].idx],
                                   PATTERN_BITS'(1) << Pos);
      end else begin : g_pass
        assign chain[j+1] = chain[j];
      end
    end
    assign st_d[s]  = chain[STEPS_PER_STAGE];
    assign vld_d[s] = vld_q[s-1];
  end

  // stage enables: a stage loads when empty or when the next one moves
  assign en[NumStg] = !vld_q[NumStg] || out_ready_i;
  for (genvar s = 0; s < NumStg; s++) begin : g_en
    assign en[s] = !vld_q[s] || en[s+1];
  end

  // stage registers
  for (genvar s = 0; s <= NumStg; s++) begin : g_reg
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en[s]) begin
        vld_q[s] <= vld_d[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[s]) begin
        st_q[s] <= st_d[s];
      end
    end
  end

  // result formatting
  logic [PATTERN_BITS+PATTERN_W-1:0] pout_ext;
  stg_t                              last;

  assign last     = st_q[NumStg];
  assign pout_ext = {{PATTERN_W{1'b0}}, last.pat};

  assign in_ready_o               = en[0];
  assign out_valid_o              = vld_q[NumStg];
  assign out_data_o.pattern_out   = pout_ext[PATTERN_W-1:0];
  assign out_data_o.rank_out      = (last.cmd == CMD_ENCODE) ? last.acc[RANK_W-1:0] : last.rank;
  assign out_data_o.popcount_out  = last.k;
  assign out_data_o.code_width    = last.cw;
  assign out_data_o.rank_error    = last.err;

endmodule

// ===== hw/rtl/cmbrc16_chk.sv =====
// port-level checker for the combinadic rank codec, bound to the top level
// depends on cmbrc16_pkg and combinadic_rank_codec16_macros.svh
`include "combinadic_rank_codec16_macros.svh"

module cmbrc16_chk #(
  parameter int unsigned PATTERN_BITS = cmbrc16_pkg::PATTERN_BITS_DEF
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input cmbrc16_pkg::out_t out_data_i
);
  import cmbrc16_pkg::*;

  // a stalled result item holds
  `CMB_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_data_i), "result item changed while stalled")

  // an empty output stage means the pipeline can take an item
  `CMB_ASSERT(a_empty_ready, clk_i, rst_ni, !out_valid_i, in_ready_i, "input blocked with empty output stage")

  // a rejected rank gives an empty pattern
  `CMB_ASSERT(a_err_zero, clk_i, rst_ni, out_valid_i && out_data_i.rank_error, out_data_i.pattern_out == '0, "rank error with nonzero pattern")

  // a good result carries as many set bits as its popcount
  `CMB_ASSERT(a_pop_match, clk_i, rst_ni, out_valid_i && !out_data_i.rank_error && (PATTERN_BITS <= PATTERN_W), $countones(out_data_i.pattern_out) == out_data_i.popcount_out, "pattern and popcount disagree")

endmodule

bind combinadic_rank_codec16 cmbrc16_chk #(
  .PATTERN_BITS(PATTERN_BITS)
) u_cmbrc16_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_ready_o),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_i  (out_data_o)
);

// ===== verif/combinadic_rank_codec16_tb.sv =====
// self-checking bench for combinadic_rank_codec16: directed corners, then random items
// under several idle and stall mixes; depends on cmbrc16_pkg and the codec top level only
module combinadic_rank_codec16_tb;
  import cmbrc16_pkg::*;

  localparam int unsigned WIDTH      = 16;
  localparam int unsigned PHASE_ITEMS = 175;
  localparam int unsigned DRAIN_CYCLES = 30;
  localparam int unsigned QUIET_LIMIT  = 2000;

  // expected results of accepted items, with the codec arithmetic worked out here
  class rank_ledger;
    int unsigned pascal [0:WIDTH][0:WIDTH];
    out_t        queued_codes [$];
    int unsigned fail_count;
    int unsigned result_count;

    function new();
      for (int n = 0; n <= WIDTH; n++) begin
        for (int r = 0; r <= WIDTH; r++) begin
          if (r > n) pascal[n][r] = 0;
          else if (r == 0 || r == n) pascal[n][r] = 1;
          else pascal[n][r] = pascal[n-1][r-1] + pascal[n-1][r];
        end
      end
      fail_count   = 0;
      result_count = 0;
    endfunction

    // number of full-width patterns with k set bits, zero past the width
    function int unsigned band_size(int unsigned k);
      return (k > WIDTH) ? 0 : pascal[WIDTH][k];
    endfunction

    // rank, popcount, packing width and pattern for one item
    function out_t codec_outcome(in_t d);
      out_t        res;
      int unsigned rem;
      int unsigned pos;
      int unsigned nth;
      int unsigned count;
      res = '0;
      if (d.command == CMD_ENCODE) begin
        nth = 0;
        for (int p = 0; p < WIDTH; p++) begin
          if (d.pattern_in[p]) begin
            nth++;
            res.rank_out = res.rank_out + RANK_W'(pascal[p][nth]);
          end
        end
        res.pattern_out  = d.pattern_in;
        res.popcount_out = COUNT_W'(nth);
      end else begin
        res.rank_out     = d.rank_in;
        res.popcount_out = d.popcount_in;
        if (d.rank_in >= band_size(d.popcount_in)) begin
          res.rank_error = 1'b1;
        end else begin
          // greedy descent from the top set bit down
          rem = d.rank_in;
          for (int i = d.popcount_in; i >= 1; i--) begin
            pos = i - 1;
            while (pos + 1 < WIDTH && pascal[pos+1][i] <= rem) pos++;
            res.pattern_out[pos] = 1'b1;
            rem = rem - pascal[pos][i];
          end
        end
      end
      count = band_size(res.popcount_out);
      if (count > 1) begin
        while ((32'd1 << res.code_width) < count) res.code_width++;
      end
      return res;
    endfunction

    task report(string msg);
      fail_count++;
      // keep the log bounded on a badly broken build
      if (fail_count <= 100) $display("mismatch: %s", msg);
    endtask

    task log_request(in_t d);
      queued_codes.push_back(codec_outcome(d));
    endtask

    task check_result(out_t got);
      out_t  want;
      string bad;
      result_count++;
      if (queued_codes.size() == 0) begin
        report($sformatf("result %0d arrived with nothing pending: %h", result_count, got));
      end else begin
        want = queued_codes.pop_front();
        bad  = "";
        if (got.pattern_out !== want.pattern_out) bad = {bad, " pattern_out"};
        if (got.rank_out !== want.rank_out) bad = {bad, " rank_out"};
        if (got.popcount_out !== want.popcount_out) bad = {bad, " popcount_out"};
        if (got.code_width !== want.code_width) bad = {bad, " code_width"};
        if (got.rank_error !== want.rank_error) bad = {bad, " rank_error"};
        if (bad != "") begin
          report($sformatf("result %0d%s: got %h want %h", result_count, bad, got, want));
        end
      end
    endtask
  endclass

  logic clk_i;
  logic rst_ni    = 1'b0;
  logic in_valid  = 1'b0;
  in_t  in_data   = '0;
  logic out_ready = 1'b0;
  logic in_ready;
  logic out_valid;
  out_t out_data;

  int unsigned src_idle_pct  = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned quiet_cycles  = 0;
  rank_ledger  ledger;

  combinadic_rank_codec16 dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // receiver back-pressure
  always @(posedge clk_i) begin
    out_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // handshake monitor, scoreboard hookup and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (in_valid && in_ready) ledger.log_request(in_data);
      if (out_valid && out_ready) ledger.check_result(out_data);
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // present one item, holding it until the codec takes it
  task automatic send_item(input in_t d);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    do @(posedge clk_i); while (!in_ready);
  endtask

  function automatic in_t make_item(cmd_e cmd, logic [15:0] pat, logic [13:0] rnk,
                                    logic [4:0] cnt);
    in_t d;
    d.command     = cmd;
    d.pattern_in  = pat;
    d.rank_in     = rnk;
    d.popcount_in = cnt;
    return d;
  endfunction

  // mostly well-formed decodes and encodes spread over all popcounts, some bad ranks
  function automatic in_t random_item();
    in_t         d;
    int unsigned k;
    int unsigned pick;
    d.command     = CMD_DECODE;
    d.pattern_in  = 16'($urandom);
    d.rank_in     = 14'($urandom);
    d.popcount_in = 5'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      d.command = CMD_ENCODE;
      case ($urandom_range(0, 3))
        0: d.pattern_in = 16'($urandom);
        1: d.pattern_in = 16'($urandom & $urandom & $urandom);
        2: d.pattern_in = 16'($urandom | $urandom | $urandom);
        default: d.pattern_in = (16'hFFFF >> $urandom_range(0, 16)) << $urandom_range(0, 15);
      endcase
    end else if (pick < 85) begin
      k = $urandom_range(0, WIDTH);
      d.popcount_in = 5'(k);
      d.rank_in     = 14'($urandom_range(0, ledger.band_size(k) - 1));
    end else if (pick < 93) begin
      k = $urandom_range(0, WIDTH);
      d.popcount_in = 5'(k);
      d.rank_in     = 14'($urandom_range(ledger.band_size(k), 16383));
    end else begin
      d.popcount_in = 5'($urandom_range(WIDTH + 1, 31));
    end
    return d;
  endfunction

  // stimulus
  initial begin
    in_t directed [$];
    int unsigned idle_mix [4][2];
    ledger   = new();
    idle_mix = '{'{0, 0}, '{70, 0}, '{0, 70}, '{6, 6}};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // pattern extremes, max rank band, and decode range edges
    directed.push_back(make_item(CMD_ENCODE, 16'h0000, 14'h0000, 5'd0));
    directed.push_back(make_item(CMD_ENCODE, 16'hFFFF, 14'h3FFF, 5'd31));
    directed.push_back(make_item(CMD_ENCODE, 16'h0001, 14'h0000, 5'd0));
    directed.push_back(make_item(CMD_ENCODE, 16'h8000, 14'h0000, 5'd0));
    directed.push_back(make_item(CMD_ENCODE, 16'hFF00, 14'h0000, 5'd0));
    directed.push_back(make_item(CMD_ENCODE, 16'h00FF, 14'h0000, 5'd0));
    directed.push_back(make_item(CMD_ENCODE, 16'hAAAA, 14'h0000, 5'd0));
    directed.push_back(make_item(CMD_ENCODE, 16'h5555, 14'h0000, 5'd0));
    directed.push_back(make_item(CMD_DECODE, 16'hFFFF, 14'd0, 5'd0));
    directed.push_back(make_item(CMD_DECODE, 16'h0000, 14'd1, 5'd0));
    directed.push_back(make_item(CMD_DECODE, 16'h0000, 14'd0, 5'd16));
    directed.push_back(make_item(CMD_DECODE, 16'h0000, 14'd1, 5'd16));
    directed.push_back(make_item(CMD_DECODE, 16'h0000, 14'd0, 5'd1));
    directed.push_back(make_item(CMD_DECODE, 16'h0000, 14'd15, 5'd1));
    directed.push_back(make_item(CMD_DECODE, 16'h0000, 14'd16, 5'd1));
    directed.push_back(make_item(CMD_DECODE, 16'h0000, 14'd12869, 5'd8));
    directed.push_back(make_item(CMD_DECODE, 16'h0000, 14'd12870, 5'd8));
    directed.push_back(make_item(CMD_DECODE, 16'h0000, 14'd0, 5'd17));
    directed.push_back(make_item(CMD_DECODE, 16'hFFFF, 14'd16383, 5'd31));
    directed.push_back(make_item(CMD_DECODE, 16'h0000, 14'd5000, 5'd7));
    directed.push_back(make_item(CMD_DECODE, 16'h0000, 14'd0, 5'd15));
    directed.push_back(make_item(CMD_DECODE, 16'h0000, 14'd15, 5'd15));
    directed.push_back(make_item(CMD_DECODE, 16'h0000, 14'd16, 5'd15));
    foreach (directed[i]) send_item(directed[i]);

    // random items, one idle/stall mix per phase
    for (int ph = 0; ph < 4; ph++) begin
      src_idle_pct   = idle_mix[ph][0];
      sink_stall_pct = idle_mix[ph][1];
      repeat (PHASE_ITEMS) send_item(random_item());
    end
    in_valid <= 1'b0;

    // drain
    while (ledger.queued_codes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (ledger.fail_count == 0 && ledger.queued_codes.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== combinadic_rank_codec16.f =====
+incdir+hw/rtl
hw/rtl/cmbrc16_pkg.sv
hw/rtl/combinadic_rank_codec16.sv
hw/rtl/cmbrc16_chk.sv
verif/combinadic_rank_codec16_tb.sv
